// File: rtl/modular_matrix_power_core_assert.svh
// assertion macros shared by the modular matrix power core
`ifndef MODULAR_MATRIX_POWER_CORE_ASSERT_SVH
`define MODULAR_MATRIX_POWER_CORE_ASSERT_SVH

// property checked on every rising clock edge outside of reset
`define MMP_ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define MMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mmp_pkg.sv
// types and constants of the modular matrix power core
`default_nettype none

package mmp_pkg;

  localparam int unsigned MaxDim   = 8;
  localparam int unsigned ElemBits = 32;
  localparam int unsigned ModSteps = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDX,
    ST_RDY,
    ST_MUL,
    ST_MOD,
    ST_ACC,
    ST_NEXT,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_PROD,
    OP_RMUL,
    OP_SSQ
  } mop_e;

  typedef enum logic [2:0] {
    CFG_MODE,
    CFG_ROWS,
    CFG_INNER,
    CFG_COLS,
    CFG_MODULUS,
    CFG_EXPONENT
  } cfg_idx_e;

  typedef enum logic {
    MODE_PRODUCT,
    MODE_POWER
  } mode_e;

  typedef enum logic {
    LD_FIRST,
    LD_SECOND
  } ld_sel_e;

endpackage

`default_nettype wire

// File: rtl/mmp_ram.sv
// generic single write port ram with registered read
`default_nettype none

module mmp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/modular_matrix_power_core.sv
// modular matrix product and square-and-multiply matrix power engine
//
// configuration: write cfg_wdata_i to register cfg_addr_i while cfg_we_i is high
// (mode, rows, inner, cols, modulus, exponent); only while busy_o is low.
// loading: an element transfer happens when start_i is high and busy_o is low;
// op_i picks the first or second matrix, row_index_i/col_index_i the entry.
// an element with last_i set is stored and then starts the computation.
// each product term runs two memory reads on one port, one 32x32 multiply,
// a 64-step bit-serial remainder and a modular add; the power runs one
// product per set exponent bit plus one squaring per further bit.
// running result and scratch matrices live in ping-pong memory banks, so a
// product never writes the bank it reads from; no clearing pass is needed.
// results stream out one per cycle in row-major order with out_valid_o,
// starting after the last product; out_last_o marks the final one.
// the receiver cannot stall; busy_o stays high until the last result is out.
// reset returns the controller to idle and config registers to their defaults;
// matrix memories keep whatever they held.
`default_nettype none

module modular_matrix_power_core #(
  parameter int unsigned MAX_DIM   = mmp_pkg::MaxDim,
  parameter int unsigned ELEM_BITS = mmp_pkg::ElemBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        op_i,
  input  wire logic [2:0]  row_index_i,
  input  wire logic [2:0]  col_index_i,
  input  wire logic [31:0] value_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  output logic [2:0]       out_row_o,
  output logic [2:0]       out_col_o,
  output logic [31:0]      out_value_o,
  output logic             out_last_o
);

  localparam int unsigned Cells = MAX_DIM * MAX_DIM;
  localparam int unsigned AW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam logic [AW-1:0] DimStride = AW'(MAX_DIM);
  localparam logic [2:0] DimLast = 3'(MAX_DIM - 1);
  localparam logic [5:0] ModLastStep = 6'(mmp_pkg::ModSteps - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
    return AW'(r) * DimStride + AW'(c);
  endfunction

  function automatic logic [2:0] dim_last(input logic [3:0] d);
    logic [2:0] res;
    if (d == 4'd0) begin
      res = 3'd0;
    end else if (32'(d) > MAX_DIM) begin
      res = DimLast;
    end else begin
      res = 3'(d - 4'd1);
    end
    return res;
  endfunction

  // configuration registers
  logic        mode_q;
  logic [3:0]  rows_q, inner_q, cols_q;
  logic [31:0] modulus_q;
  logic [63:0] exponent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= mmp_pkg::MODE_POWER;
      rows_q     <= 4'd2;
      inner_q    <= 4'd2;
      cols_q     <= 4'd2;
      modulus_q  <= 32'd1000000007;
      exponent_q <= 64'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        mmp_pkg::CFG_MODE:     mode_q     <= cfg_wdata_i[0];
        mmp_pkg::CFG_ROWS:     rows_q     <= cfg_wdata_i[3:0];
        mmp_pkg::CFG_INNER:    inner_q    <= cfg_wdata_i[3:0];
        mmp_pkg::CFG_COLS:     cols_q     <= cfg_wdata_i[3:0];
        mmp_pkg::CFG_MODULUS:  modulus_q  <= cfg_wdata_i[31:0];
        mmp_pkg::CFG_EXPONENT: exponent_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // controller and datapath registers
  mmp_pkg::state_e state_q, state_d;
  mmp_pkg::mop_e   op_q, op_d;
  logic [2:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [2:0]  lr_q, lr_d, lk_q, lk_d, lc_q, lc_d;
  logic        r_sel_q, r_sel_d, s_sel_q, s_sel_d;
  logic        r_ident_q, r_ident_d, s_in_a_q, s_in_a_d;
  logic [63:0] e_q, e_d;
  logic [31:0] x_q, x_d;
  logic [63:0] prod_q, prod_d;
  logic [31:0] rem_q, rem_d, acc_q, acc_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        pend_q, pend_d, pend_last_q, pend_last_d;
  logic [2:0]  pend_row_q, pend_row_d, pend_col_q, pend_col_d;

  logic start_ok, run_go, load_ok;
  assign start_ok = start_i && !busy_o;
  assign run_go   = start_ok && last_i;
  assign load_ok  = start_ok && (32'(row_index_i) < MAX_DIM) && (32'(col_index_i) < MAX_DIM);

  // memories
  logic [AW-1:0]        rd_addr, load_addr, dst_addr;
  logic [ELEM_BITS-1:0] a_rdata, b_rdata;
  logic [31:0]          r_rdata [2];
  logic [31:0]          s_rdata [2];
  logic                 dst_we, dst_is_s;
  logic [31:0]          acc_new;

  assign load_addr = cell_addr(row_index_i, col_index_i);
  assign dst_addr  = cell_addr(i_q, j_q);
  assign dst_we    = (state_q == mmp_pkg::ST_ACC) && (k_q == lk_q);
  assign dst_is_s  = (op_q == mmp_pkg::OP_SSQ);

  mmp_ram #(.WIDTH(ELEM_BITS), .DEPTH(Cells)) u_mem_a (
    .clk_i   (clk_i),
    .we_i    (load_ok && (op_i == mmp_pkg::LD_FIRST)),
    .waddr_i (load_addr),
    .wdata_i (value_i[ELEM_BITS-1:0]),
    .raddr_i (rd_addr),
    .rdata_o (a_rdata)
  );

  mmp_ram #(.WIDTH(ELEM_BITS), .DEPTH(Cells)) u_mem_b (
    .clk_i   (clk_i),
    .we_i    (load_ok && (op_i == mmp_pkg::LD_SECOND)),
    .waddr_i (load_addr),
    .wdata_i (value_i[ELEM_BITS-1:0]),
    .raddr_i (rd_addr),
    .rdata_o (b_rdata)
  );

  // ping-pong banks: results always go to the bank not being read
  for (genvar b = 0; b < 2; b++) begin : g_bank
    mmp_ram #(.WIDTH(32), .DEPTH(Cells)) u_mem_r (
      .clk_i   (clk_i),
      .we_i    (dst_we && !dst_is_s && (1'(b) != r_sel_q)),
      .waddr_i (dst_addr),
      .wdata_i (acc_new),
      .raddr_i (rd_addr),
      .rdata_o (r_rdata[b])
    );
    mmp_ram #(.WIDTH(32), .DEPTH(Cells)) u_mem_s (
      .clk_i   (clk_i),
      .we_i    (dst_we && dst_is_s && (1'(b) != s_sel_q)),
      .waddr_i (dst_addr),
      .wdata_i (acc_new),
      .raddr_i (rd_addr),
      .rdata_o (s_rdata[b])
    );
  end

  // operand selection
  logic [31:0] a_word, b_word, s_word, x_word, y_word;
  assign a_word = 32'(a_rdata);
  assign b_word = 32'(b_rdata);
  assign s_word = s_in_a_q ? a_word : s_rdata[s_sel_q];

  always_comb begin
    unique case (op_q)
      mmp_pkg::OP_PROD: x_word = a_word;
      mmp_pkg::OP_RMUL: x_word = r_ident_q ? ((i_q == k_q) ? 32'd1 : 32'd0) : r_rdata[r_sel_q];
      mmp_pkg::OP_SSQ:  x_word = s_word;
      default:          x_word = a_word;
    endcase
  end
  assign y_word = (op_q == mmp_pkg::OP_PROD) ? b_word : s_word;

  always_comb begin
    unique case (state_q)
      mmp_pkg::ST_RDX: rd_addr = cell_addr(i_q, k_q);
      mmp_pkg::ST_OUT: rd_addr = cell_addr(i_q, j_q);
      default:         rd_addr = cell_addr(k_q, j_q);
    endcase
  end

  // modulus zero acts as 2^32
  logic [32:0] m_ext, step_t, step_r, acc_sum;
  logic [31:0] acc_base;
  assign m_ext    = (modulus_q == 32'd0) ? 33'h1_0000_0000 : {1'b0, modulus_q};
  assign step_t   = {rem_q, prod_q[63]};
  assign step_r   = (step_t >= m_ext) ? (step_t - m_ext) : step_t;
  assign acc_base = (k_q == 3'd0) ? 32'd0 : acc_q;
  assign acc_sum  = {1'b0, acc_base} + {1'b0, rem_q};
  assign acc_new  = (acc_sum >= m_ext) ? 32'(acc_sum - m_ext) : acc_sum[31:0];

  logic term_last, mat_last;
  assign mat_last  = (i_q == lr_q) && (j_q == lc_q);
  assign term_last = (k_q == lk_q) && mat_last;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mmp_pkg::ST_IDLE: begin
        if (run_go) begin
          if (mode_q == mmp_pkg::MODE_POWER && exponent_q == 64'd0) begin
            state_d = mmp_pkg::ST_OUT;
          end else begin
            state_d = mmp_pkg::ST_RDX;
          end
        end
      end
      mmp_pkg::ST_RDX: state_d = mmp_pkg::ST_RDY;
      mmp_pkg::ST_RDY: state_d = mmp_pkg::ST_MUL;
      mmp_pkg::ST_MUL: state_d = mmp_pkg::ST_MOD;
      mmp_pkg::ST_MOD: begin
        if (cnt_q == ModLastStep) begin
          state_d = mmp_pkg::ST_ACC;
        end
      end
      mmp_pkg::ST_ACC: state_d = term_last ? mmp_pkg::ST_NEXT : mmp_pkg::ST_RDX;
      mmp_pkg::ST_NEXT: begin
        unique case (op_q)
          mmp_pkg::OP_PROD: state_d = mmp_pkg::ST_OUT;
          mmp_pkg::OP_RMUL: state_d = (e_q[63:1] != 63'd0) ? mmp_pkg::ST_RDX : mmp_pkg::ST_OUT;
          default:          state_d = mmp_pkg::ST_RDX;
        endcase
      end
      mmp_pkg::ST_OUT: begin
        if (mat_last) begin
          state_d = mmp_pkg::ST_IDLE;
        end
      end
      default: state_d = mmp_pkg::ST_IDLE;
    endcase
  end

  // datapath and output updates
  always_comb begin
    op_d        = op_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    lr_d        = lr_q;
    lk_d        = lk_q;
    lc_d        = lc_q;
    r_sel_d     = r_sel_q;
    s_sel_d     = s_sel_q;
    r_ident_d   = r_ident_q;
    s_in_a_d    = s_in_a_q;
    e_d         = e_q;
    x_d         = x_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pend_row_d  = pend_row_q;
    pend_col_d  = pend_col_q;
    pend_last_d = pend_last_q;
    unique case (state_q)
      mmp_pkg::ST_IDLE: begin
        if (run_go) begin
          i_d  = 3'd0;
          j_d  = 3'd0;
          k_d  = 3'd0;
          lr_d = dim_last(rows_q);
          if (mode_q == mmp_pkg::MODE_PRODUCT) begin
            lk_d      = dim_last(inner_q);
            lc_d      = dim_last(cols_q);
            op_d      = mmp_pkg::OP_PROD;
            r_ident_d = 1'b0;
          end else begin
            lk_d      = dim_last(rows_q);
            lc_d      = dim_last(rows_q);
            r_ident_d = 1'b1;
            s_in_a_d  = 1'b1;
            e_d       = exponent_q;
            op_d      = exponent_q[0] ? mmp_pkg::OP_RMUL : mmp_pkg::OP_SSQ;
          end
        end
      end
      mmp_pkg::ST_RDY: x_d = x_word;
      mmp_pkg::ST_MUL: begin
        prod_d = 64'(x_q) * 64'(y_word);
        rem_d  = 32'd0;
        cnt_d  = 6'd0;
      end
      mmp_pkg::ST_MOD: begin
        rem_d  = step_r[31:0];
        prod_d = prod_q << 1;
        cnt_d  = cnt_q + 6'd1;
      end
      mmp_pkg::ST_ACC: begin
        acc_d = acc_new;
        if (k_q != lk_q) begin
          k_d = k_q + 3'd1;
        end else begin
          k_d = 3'd0;
          if (j_q != lc_q) begin
            j_d = j_q + 3'd1;
          end else begin
            j_d = 3'd0;
            i_d = (i_q != lr_q) ? (i_q + 3'd1) : 3'd0;
          end
        end
      end
      mmp_pkg::ST_NEXT: begin
        unique case (op_q)
          mmp_pkg::OP_SSQ: begin
            s_sel_d  = ~s_sel_q;
            s_in_a_d = 1'b0;
            e_d      = e_q >> 1;
            op_d     = e_q[1] ? mmp_pkg::OP_RMUL : mmp_pkg::OP_SSQ;
          end
          default: begin
            r_sel_d   = ~r_sel_q;
            r_ident_d = 1'b0;
            if (op_q == mmp_pkg::OP_RMUL) begin
              op_d = mmp_pkg::OP_SSQ;
            end
          end
        endcase
      end
      mmp_pkg::ST_OUT: begin
        pend_d      = 1'b1;
        pend_row_d  = i_q;
        pend_col_d  = j_q;
        pend_last_d = mat_last;
        if (j_q != lc_q) begin
          j_d = j_q + 3'd1;
        end else begin
          j_d = 3'd0;
          i_d = (i_q != lr_q) ? (i_q + 3'd1) : 3'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mmp_pkg::ST_IDLE;
      op_q      <= mmp_pkg::OP_PROD;
      i_q       <= 3'd0;
      j_q       <= 3'd0;
      k_q       <= 3'd0;
      lr_q      <= 3'd0;
      lk_q      <= 3'd0;
      lc_q      <= 3'd0;
      r_sel_q   <= 1'b0;
      s_sel_q   <= 1'b0;
      r_ident_q <= 1'b0;
      s_in_a_q  <= 1'b0;
      e_q       <= 64'd0;
      cnt_q     <= 6'd0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      lr_q      <= lr_d;
      lk_q      <= lk_d;
      lc_q      <= lc_d;
      r_sel_q   <= r_sel_d;
      s_sel_q   <= s_sel_d;
      r_ident_q <= r_ident_d;
      s_in_a_q  <= s_in_a_d;
      e_q       <= e_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    prod_q      <= prod_d;
    rem_q       <= rem_d;
    acc_q       <= acc_d;
    pend_row_q  <= pend_row_d;
    pend_col_q  <= pend_col_d;
    pend_last_q <= pend_last_d;
  end

  assign busy_o      = (state_q != mmp_pkg::ST_IDLE) || pend_q;
  assign out_valid_o = pend_q;
  assign out_row_o   = pend_row_q;
  assign out_col_o   = pend_col_q;
  assign out_last_o  = pend_last_q;
  // identity result is unreduced
  assign out_value_o = r_ident_q ? ((pend_row_q == pend_col_q) ? 32'd1 : 32'd0)
                                 : r_rdata[r_sel_q];

`include "modular_matrix_power_core_assert.svh"

  `MMP_ASSERT_NEXT(a_last_result_ends, out_valid_o && out_last_o, !out_valid_o, "result after last")
  `MMP_ASSERT_AT(a_no_result_in_calc, ((state_q != mmp_pkg::ST_IDLE) && (state_q != mmp_pkg::ST_OUT)) |-> !pend_q, "result during computation")
  `MMP_ASSERT_NEXT(a_start_sets_busy, run_go, busy_o, "computation start without busy")
  `MMP_ASSERT_NEXT(a_final_term_next, (state_q == mmp_pkg::ST_ACC) && term_last, state_q == mmp_pkg::ST_NEXT, "matrix end missed")

endmodule

`default_nettype wire
